// ----- design/aws_pkg.sv -----
// ---------------------------------------------------------------------------
// Accumulated-weight slot scheduler package
// Widths, port layout constants and shared types.
// ---------------------------------------------------------------------------
package aws_pkg;

	// Fixed field widths.
	localparam int WEIGHT_W      = 16;
	localparam int WEIGHT_FIELDS = 8;
	localparam int ACC_W         = 32;
	localparam int CHOICE_W      = 4;

	// Stream payload widths.
	localparam int IN_TDATA_W  = WEIGHT_FIELDS * WEIGHT_W;
	localparam int OUT_TDATA_W = 8;

	localparam logic [WEIGHT_W-1:0] IDLE_WEIGHT_RST = 16'd256;
	localparam logic [ACC_W-1:0]    ACC_MAX         = {ACC_W{1'b1}};

	// Control from the slot stage to the accumulator bank.
	typedef struct packed {
		logic                update;
		logic                first_of_plan;
		logic [CHOICE_W-1:0] winner;
	} bank_ctl_t;

endpackage

// ----- design/aws_credit_bank.sv -----
// ---------------------------------------------------------------------------
// Accumulator bank
// Holds one saturating accumulator per location plus the idle accumulator,
// forms this slot's sums and commits them with the winner cleared.
// ---------------------------------------------------------------------------
module aws_credit_bank
	import aws_pkg::*;
#(
	parameter int LOCATIONS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bank_ctl_t                             ctl,
	input  logic [LOCATIONS-1:0][WEIGHT_W-1:0]    weight,
	input  logic [WEIGHT_W-1:0]                   idle_weight,
	output logic [LOCATIONS:0][ACC_W-1:0]         sums
);

	localparam int NUM_ACC = LOCATIONS + 1;

	logic [NUM_ACC-1:0][ACC_W-1:0]    acc_q;
	logic [NUM_ACC-1:0][WEIGHT_W-1:0] addend;
	logic [NUM_ACC-1:0][ACC_W:0]      raw_sum;

	for (genvar p = 0; p < NUM_ACC; p++) begin : g_acc
		if (p < LOCATIONS) begin : g_loc
			assign addend[p] = weight[p];
		end else begin : g_idle
			assign addend[p] = idle_weight;
		end

		// A first slot of a plan starts every accumulator from zero.
		assign raw_sum[p] = {1'b0, (ctl.first_of_plan ? '0 : acc_q[p])}
			+ {{(ACC_W + 1 - WEIGHT_W){1'b0}}, addend[p]};
		assign sums[p] = raw_sum[p][ACC_W] ? ACC_MAX : raw_sum[p][ACC_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[p] <= '0;
			end else if (ctl.update) begin
				acc_q[p] <= (ctl.winner == CHOICE_W'(p)) ? '0 : sums[p];
			end
		end
	end

endmodule

// ----- design/aws_argmax.sv -----
// ---------------------------------------------------------------------------
// Maximum selector
// Balanced compare tree that returns the index of the largest sum, the
// lowest index among equal maxima.
// ---------------------------------------------------------------------------
module aws_argmax
	import aws_pkg::*;
#(
	parameter int LOCATIONS = 8
) (
	input  logic [LOCATIONS:0][ACC_W-1:0] sums,
	output logic [CHOICE_W-1:0]           winner
);

	localparam int NUM_ACC = LOCATIONS + 1;
	localparam int LEVELS  = $clog2(NUM_ACC);
	localparam int LEAVES  = 1 << LEVELS;

	logic [LEVELS:0][LEAVES-1:0][ACC_W-1:0]    val;
	logic [LEVELS:0][LEAVES-1:0][CHOICE_W-1:0] idx;

	always_comb begin
		val = '0;
		idx = '0;
		// Padding leaves sit to the right with value zero, so they never win.
		for (int n = 0; n < LEAVES; n++) begin
			idx[0][n] = CHOICE_W'(n);
			if (n < NUM_ACC) begin
				val[0][n] = sums[n];
			end
		end
		// The left entry wins ties, which keeps the lowest index.
		for (int lv = 0; lv < LEVELS; lv++) begin
			for (int n = 0; n < (LEAVES >> (lv + 1)); n++) begin
				if (val[lv][2*n] >= val[lv][2*n+1]) begin
					val[lv+1][n] = val[lv][2*n];
					idx[lv+1][n] = idx[lv][2*n];
				end else begin
					val[lv+1][n] = val[lv][2*n+1];
					idx[lv+1][n] = idx[lv][2*n+1];
				end
			end
		end
		winner = idx[LEVELS][0];
	end

endmodule

// ----- design/accumulated_weight_slot_scheduler_core.sv -----
// ---------------------------------------------------------------------------
// Accumulated-weight slot scheduler core
// Accumulates per-location slot weights and picks one location per slot.
// ---------------------------------------------------------------------------
// The block takes one slot word per clock while the output is not stalled and
// returns one choice word per slot; each slot passes through the slot register
// and then the result register. Throughput is one slot per cycle unless the
// output stalls; the path that sets the clock is the saturating accumulator add
// followed by the four-level compare tree that finds the largest accumulator. A
// choice equal to LOCATIONS means idle. Write idle_weight only while no slot is
// in flight.
module accumulated_weight_slot_scheduler_core
	import aws_pkg::*;
#(
	parameter int LOCATIONS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [WEIGHT_W-1:0]    cfg_wdata,     // idle_weight
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,       // weight_0 .. weight_7, 16 bits each
	input  logic                   s_tuser,       // first_of_plan
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata        // choice, then zero padding
);

	logic [WEIGHT_W-1:0]                idle_weight_q;
	logic                               valid_s1;
	logic                               first_s1;
	logic [LOCATIONS-1:0][WEIGHT_W-1:0] weight_s1;
	logic                               out_valid_q;
	logic [CHOICE_W-1:0]                choice_q;
	logic                               advance;
	logic [LOCATIONS:0][ACC_W-1:0]      sums;
	logic [CHOICE_W-1:0]                winner;
	bank_ctl_t                          bank_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_weight_q <= IDLE_WEIGHT_RST;
		end else if (cfg_we) begin
			idle_weight_q <= cfg_wdata;
		end
	end

	// The slot stage moves on when the result register is free or emptying.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			first_s1 <= s_tuser;
			for (int p = 0; p < LOCATIONS; p++) begin
				weight_s1[p] <= s_tdata[p*WEIGHT_W +: WEIGHT_W];
			end
		end
	end

	assign bank_ctl = '{update: advance, first_of_plan: first_s1, winner: winner};

	aws_credit_bank #(
		.LOCATIONS (LOCATIONS)
	) u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (bank_ctl),
		.weight      (weight_s1),
		.idle_weight (idle_weight_q),
		.sums        (sums)
	);

	aws_argmax #(
		.LOCATIONS (LOCATIONS)
	) u_argmax (
		.sums   (sums),
		.winner (winner)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			choice_q <= winner;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - CHOICE_W){1'b0}}, choice_q};

`ifndef ASSERT_OFF
	a_choice_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CHOICE_W-1:0] <= CHOICE_W'(LOCATIONS)))
		else $error("choice beyond the idle index");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the result register is empty");

	a_accept_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted slot did not reach the slot stage");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed slot produced no result");
`endif

endmodule

// ----- tb/accumulated_weight_slot_scheduler_core_tb.sv -----
// ---------------------------------------------------------------------------
// Accumulated-weight slot scheduler core testbench
// Streams slot words with random gaps and output stalls. A predictor keeps its
// own accumulators and idle weight and computes the expected choice for each
// accepted slot. Every choice word is checked in order against it. The
// idle_weight register is changed between phases, while nothing is in flight.
// ---------------------------------------------------------------------------
module accumulated_weight_slot_scheduler_core_tb;
	import aws_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOC = 8;

	typedef struct packed {
		logic                                     first_of_plan;
		logic [WEIGHT_FIELDS-1:0][WEIGHT_W-1:0]   weight;
	} slot_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [WEIGHT_W-1:0]    cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	accumulated_weight_slot_scheduler_core #(
		.LOCATIONS(LOC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state: location accumulators plus the idle one at index LOC.
	logic [ACC_W-1:0]    credit [0:LOC];
	logic [WEIGHT_W-1:0] idle_w;

	slot_t               pending_slots [$];
	logic [CHOICE_W-1:0] choice_due [$];
	int                  slots_open = 0;
	bit                  failed = 1'b0;
	logic                in_fire = 1'b0;
	int                  feed_gap = 0;
	int                  drain_stall = 0;
	bit                  feed_calm = 1'b0;
	bit                  drain_calm = 1'b0;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [WEIGHT_W-1:0] b);
		logic [ACC_W:0] sum;
		sum = {1'b0, a} + b;
		return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
	endfunction

	function automatic logic [CHOICE_W-1:0] schedule_slot(input slot_t s);
		logic [ACC_W-1:0] best;
		int               pick;
		best = '0;
		pick = 0;
		if (s.first_of_plan)
			for (int p = 0; p <= LOC; p++)
				credit[p] = '0;
		for (int p = 0; p < LOC && p < WEIGHT_FIELDS; p++)
			credit[p] = sat_add(credit[p], s.weight[p]);
		credit[LOC] = sat_add(credit[LOC], idle_w);
		// Strictly greater, so the lowest index wins a tie.
		for (int p = 0; p <= LOC; p++)
			if (credit[p] > best) begin
				best = credit[p];
				pick = p;
			end
		credit[pick] = '0;
		return CHOICE_W'(pick);
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight(input int style);
		if (style < 4)
			return WEIGHT_W'($urandom);
		if (style < 7)
			return WEIGHT_W'($urandom_range(0, 16'h0300));
		if (style == 7)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom) : 16'h0000;
	endfunction

	// Slot word driver.
	always @(negedge clk) begin
		slot_t nxt;
		logic  v;
		v = s_tvalid;
		if (arst_n && !(s_tvalid && !in_fire)) begin
			v = 1'b0;
			if (feed_gap > 0)
				feed_gap--;
			else if (pending_slots.size() > 0) begin
				nxt = pending_slots.pop_front();
				s_tdata <= nxt.weight;
				s_tuser <= nxt.first_of_plan;
				v = 1'b1;
				if ($urandom_range(0, 39) == 0)
					feed_calm = !feed_calm;
				feed_gap = pick_gap(feed_calm);
			end
		end
		s_tvalid <= v;
	end

	// Choice word receiver with random stalls.
	always @(negedge clk) begin
		if (drain_stall > 0) begin
			drain_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 39) == 0)
				drain_calm = !drain_calm;
			if ($urandom_range(0, 3) == 0)
				drain_stall = pick_gap(drain_calm);
		end
	end

	// Monitor: checks choice words and runs the predictor on accepted slots.
	always @(posedge clk) begin
		slot_t               sl;
		logic [CHOICE_W-1:0] want;
		in_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				slots_open--;
				if (choice_due.size() == 0) begin
					$error("choice: no word expected, got %0d", m_tdata[CHOICE_W-1:0]);
					failed = 1'b1;
				end else begin
					want = choice_due.pop_front();
					if (m_tdata[CHOICE_W-1:0] !== want) begin
						$error("choice: expected %0d, got %0d", want,
							m_tdata[CHOICE_W-1:0]);
						failed = 1'b1;
					end
					if (m_tdata[OUT_TDATA_W-1:CHOICE_W] !== '0) begin
						$error("pad: expected 0, got %0h",
							m_tdata[OUT_TDATA_W-1:CHOICE_W]);
						failed = 1'b1;
					end
				end
			end
			if (cfg_we)
				idle_w = cfg_wdata;
			if (s_tvalid && s_tready) begin
				sl.weight = s_tdata;
				sl.first_of_plan = s_tuser;
				choice_due.push_back(schedule_slot(sl));
			end
		end
	end

	task automatic queue_slot(input logic first,
			input logic [WEIGHT_FIELDS-1:0][WEIGHT_W-1:0] w);
		slot_t s;
		s.first_of_plan = first;
		s.weight = w;
		pending_slots.push_back(s);
		slots_open++;
	endtask

	task automatic wait_drained();
		while (slots_open > 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_idle_weight(input logic [WEIGHT_W-1:0] value);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Plans open with first_of_plan and then run on; some slots restart early.
	task automatic random_phase(input int n);
		logic [WEIGHT_FIELDS-1:0][WEIGHT_W-1:0] w;
		int style;
		for (int k = 0; k < n; k++) begin
			style = $urandom_range(0, 9);
			for (int p = 0; p < WEIGHT_FIELDS; p++)
				w[p] = pick_weight(style);
			if ($urandom_range(0, 7) == 0)
				for (int p = 1; p < WEIGHT_FIELDS; p++)
					w[p] = w[0];
			queue_slot(k == 0 || $urandom_range(0, 11) == 0, w);
		end
	endtask

	initial begin
		logic [WEIGHT_FIELDS-1:0][WEIGHT_W-1:0] w;
		for (int p = 0; p <= LOC; p++)
			credit[p] = '0;
		idle_w = IDLE_WEIGHT_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default idle weight: idle beats an empty slot, then ties.
		queue_slot(1'b1, '0);
		queue_slot(1'b1, {WEIGHT_FIELDS{16'hFFFF}});
		for (int p = 0; p < WEIGHT_FIELDS; p++) begin
			w = '0;
			w[p] = 16'h8000 | WEIGHT_W'(p);
			queue_slot(1'b0, w);
		end
		w = '0;
		w[3] = 16'h0100;
		queue_slot(1'b1, w);
		w = '0;
		w[5] = 16'h00FF;
		queue_slot(1'b1, w);
		w = '0;
		w[7] = 16'h0100;
		queue_slot(1'b1, w);

		// Zero idle weight: every accumulator zero picks location 0.
		write_idle_weight(16'h0000);
		queue_slot(1'b1, '0);
		queue_slot(1'b0, '0);
		w = '0;
		w[6] = 16'h0001;
		queue_slot(1'b0, w);

		write_idle_weight(16'hFFFF);
		queue_slot(1'b1, {WEIGHT_FIELDS{16'hFFFF}});
		queue_slot(1'b0, {WEIGHT_FIELDS{16'hFFFF}});
		queue_slot(1'b0, '0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: write_idle_weight(WEIGHT_W'($urandom));
				1: write_idle_weight(WEIGHT_W'($urandom_range(0, 16'h0300)));
				2: write_idle_weight(16'h0000);
				default: write_idle_weight(16'hFFFF);
			endcase
			random_phase(105);
		end

		while (slots_open > 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (choice_due.size() != 0) begin
			$error("choice: %0d expected words never arrived", choice_due.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("accumulated_weight_slot_scheduler_core_tb: PASS");
		else
			$display("accumulated_weight_slot_scheduler_core_tb: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("accumulated_weight_slot_scheduler_core_tb: FAIL");
		$finish;
	end

endmodule
